FILE: rtl/spsd_pkg.sv
package spsd_pkg;

    localparam int TRACKERS   = 16;
    localparam int PORT_SLOTS = 16;

    localparam int TRK_W  = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
    localparam int PS_W   = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
    localparam int CNT_W  = ($clog2(PORT_SLOTS + 1) > 5) ? $clog2(PORT_SLOTS + 1) : 5;
    localparam int MEM_AW = TRK_W + PS_W;

    localparam logic [7:0]  FLAG_SYN     = 8'h02;
    localparam logic [7:0]  FLAG_ACK     = 8'h10;
    localparam logic [16:0] TCP_MIN_HDR  = 17'd20;
    localparam logic [21:0] WINDOW_RESET = 22'd10000;
    localparam logic [4:0]  THRESH_RESET = 5'd16;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_THRESH = 1'b1;

    typedef enum logic [2:0] {
        OUT_IGNORED = 3'd0,
        OUT_NEW     = 3'd1,
        OUT_KNOWN   = 3'd2,
        OUT_ADDED   = 3'd3,
        OUT_FULL    = 3'd4
    } outcome_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
        logic [5:0]  ip_header_bytes;
        logic [15:0] ip_total_length;
        logic [31:0] now_ms;
    } pkt_t;

    typedef struct packed {
        logic [2:0] outcome;
        logic       scan_alert;
        logic [3:0] tracker_index;
        logic [4:0] distinct_ports;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_ALLOC,
        ST_PRD,
        ST_PCMP,
        ST_APPEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic ignore;
        logic scan;
        logic alloc;
        logic port_rd;
        logic port_next;
        logic known;
        logic append;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic pkt_ok;
        logic match;
        logic scan_last;
        logic port_hit;
        logic port_last;
        logic out_free;
    } ctl_sts_t;

endpackage

FILE: rtl/spsd_ctrl.sv
module spsd_ctrl
    import spsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pkt_valid,
    output logic     pkt_ready,
    input  ctl_sts_t sts,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pkt_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pkt_ready = 1'b1;
                if (pkt_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.pkt_ok)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.ignore = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.match)
                begin
                    state_next = ST_PRD;
                end
                else if (sts.scan_last)
                begin
                    state_next = ST_ALLOC;
                end
            end
            ST_ALLOC:
            begin
                cmd.alloc  = 1'b1;
                state_next = ST_DONE;
            end
            ST_PRD:
            begin
                cmd.port_rd = 1'b1;
                state_next  = ST_PCMP;
            end
            ST_PCMP:
            begin
                if (sts.port_hit)
                begin
                    cmd.known  = 1'b1;
                    state_next = ST_DONE;
                end
                else if (sts.port_last)
                begin
                    state_next = ST_APPEND;
                end
                else
                begin
                    cmd.port_next = 1'b1;
                    state_next    = ST_PRD;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/spsd_datapath.sv
module spsd_datapath
    import spsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pkt_t        pkt,
    input  logic [21:0] window_ms,
    input  logic [4:0]  port_threshold,
    input  ctl_cmd_t    cmd,
    output ctl_sts_t    sts,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    logic                 valid_reg [TRACKERS];
    logic [31:0]          source_reg [TRACKERS];
    logic [31:0]          start_reg [TRACKERS];
    logic [CNT_W-1:0]     count_reg [TRACKERS];
    logic                 alerted_reg [TRACKERS];
    logic [15:0]          port_mem [TRACKERS * (1 << PS_W)];

    pkt_t                 item_reg;
    logic [TRK_W-1:0]     trk_reg;
    logic                 free_found_reg;
    logic [TRK_W-1:0]     free_reg;
    logic [TRK_W-1:0]     oldest_reg;
    logic [31:0]          oldest_time_reg;
    logic [TRK_W-1:0]     found_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 alerted_cur_reg;
    logic [PS_W-1:0]      k_reg;
    logic [15:0]          rd_data_reg;
    res_t                 result_reg;
    res_t                 out_reg;
    logic                 out_valid_reg;

    logic                 cur_valid;
    logic [31:0]          age;
    logic                 expired;
    logic                 match;
    logic [TRK_W-1:0]     alloc_slot;
    logic [CNT_W-1:0]     thr_ext;
    logic                 addable;
    logic [CNT_W-1:0]     new_cnt;
    logic                 alert;
    logic [TRK_W+3:0]     alloc_idx_ext;
    logic [TRK_W+3:0]     found_idx_ext;
    logic [CNT_W+4:0]     cnt_ext;
    logic [CNT_W+4:0]     new_cnt_ext;
    logic [CNT_W-1:0]     k_plus;

    always_comb
    begin
        cur_valid     = valid_reg[trk_reg];
        age           = item_reg.now_ms - start_reg[trk_reg];
        expired       = cur_valid && (age > {10'd0, window_ms});
        match         = cur_valid && !expired && (source_reg[trk_reg] == item_reg.src_ip);
        alloc_slot    = free_found_reg ? free_reg : oldest_reg;
        thr_ext       = CNT_W'(port_threshold);
        addable       = (cnt_reg < thr_ext) && (cnt_reg < CNT_W'(PORT_SLOTS));
        new_cnt       = addable ? cnt_reg + 1'b1 : cnt_reg;
        alert         = (new_cnt >= thr_ext) && !alerted_cur_reg;
        alloc_idx_ext = {4'd0, alloc_slot};
        found_idx_ext = {4'd0, found_reg};
        cnt_ext       = {5'd0, cnt_reg};
        new_cnt_ext   = {5'd0, new_cnt};
        k_plus        = CNT_W'(k_reg) + 1'b1;

        sts.pkt_ok    = ({1'b0, item_reg.ip_total_length}
                         >= ({11'd0, item_reg.ip_header_bytes} + TCP_MIN_HDR))
                        && ((item_reg.tcp_flags & FLAG_SYN) != 8'd0)
                        && ((item_reg.tcp_flags & FLAG_ACK) == 8'd0);
        sts.match     = match;
        sts.scan_last = (trk_reg == TRK_W'(TRACKERS - 1));
        sts.port_hit  = (rd_data_reg == item_reg.dst_port);
        sts.port_last = (k_plus >= cnt_reg);
        sts.out_free  = !out_valid_reg || res_ready;
    end

    // control state: tracker valid bits and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TRACKERS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan && expired)
            begin
                valid_reg[trk_reg] <= 1'b0;
            end
            if (cmd.alloc)
            begin
                valid_reg[alloc_slot] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg        <= pkt;
            trk_reg         <= '0;
            free_found_reg  <= 1'b0;
            oldest_reg      <= '0;
            oldest_time_reg <= '1;
        end
        if (cmd.scan)
        begin
            trk_reg <= trk_reg + 1'b1;
            if (!cur_valid || expired)
            begin
                if (!free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_reg       <= trk_reg;
                end
            end
            else if (match)
            begin
                found_reg       <= trk_reg;
                cnt_reg         <= count_reg[trk_reg];
                alerted_cur_reg <= alerted_reg[trk_reg];
                k_reg           <= '0;
            end
            else if (start_reg[trk_reg] < oldest_time_reg)
            begin
                oldest_time_reg <= start_reg[trk_reg];
                oldest_reg      <= trk_reg;
            end
        end
        if (cmd.port_next)
        begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.alloc)
        begin
            source_reg[alloc_slot]  <= item_reg.src_ip;
            start_reg[alloc_slot]   <= item_reg.now_ms;
            count_reg[alloc_slot]   <= CNT_W'(1);
            alerted_reg[alloc_slot] <= 1'b0;
            result_reg <= '{OUT_NEW, 1'b0, alloc_idx_ext[3:0], 5'd1};
        end
        if (cmd.append)
        begin
            count_reg[found_reg] <= new_cnt;
            if (alert)
            begin
                alerted_reg[found_reg] <= 1'b1;
            end
            result_reg <= '{addable ? OUT_ADDED : OUT_FULL, alert,
                            found_idx_ext[3:0], new_cnt_ext[4:0]};
        end
        if (cmd.known)
        begin
            result_reg <= '{OUT_KNOWN, 1'b0, found_idx_ext[3:0], cnt_ext[4:0]};
        end
        if (cmd.ignore)
        begin
            result_reg <= '0;
        end
        if (cmd.emit)
        begin
            out_reg <= result_reg;
        end
    end

    // per-source port lists
    always_ff @(posedge clk)
    begin
        if (cmd.alloc)
        begin
            port_mem[{alloc_slot, PS_W'(0)}] <= item_reg.dst_port;
        end
        if (cmd.append && addable)
        begin
            port_mem[{found_reg, cnt_reg[PS_W-1:0]}] <= item_reg.dst_port;
        end
        if (cmd.port_rd)
        begin
            rd_data_reg <= port_mem[{found_reg, k_reg}];
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: rtl/syn_port_scan_detector_core.sv
// TCP SYN port-scan detector. Each packet beat carries parsed IPv4/TCP fields; a
// packet that is not a SYN without ACK, or is too short for a TCP header, yields
// an ignored result. A counted packet sweeps the tracker table one entry per
// cycle, stopping at the source's tracker, and then walks that source's port list
// in the port memory, reading each port and then comparing it; a source with no
// tracker claims a free one or the oldest instead. One packet is processed at a
// time; a finished result waits in the output register while the next packet is
// taken. window_ms sits at address 0x0, port_threshold at 0x4; write them only
// while the block is idle.
module syn_port_scan_detector_core
    import spsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pkt_valid,
    output logic        pkt_ready,
    input  pkt_t        pkt,
    output logic        res_valid,
    input  logic        res_ready,
    output res_t        res
);

    logic [21:0] window_reg;
    logic [4:0]  thresh_reg;
    ctl_cmd_t    cmd;
    ctl_sts_t    sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            thresh_reg <= THRESH_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_WINDOW)
            begin
                window_reg <= pwdata[21:0];
            end
            else
            begin
                thresh_reg <= pwdata[4:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESH) ? {27'd0, thresh_reg} : {10'd0, window_reg};

    spsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    spsd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .pkt            (pkt),
        .window_ms      (window_reg),
        .port_threshold (thresh_reg),
        .cmd            (cmd),
        .sts            (sts),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

endmodule

FILE: tb/scan_checker.sv
module scan_checker
    import spsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        pkt_valid,
    input  logic        pkt_ready,
    input  pkt_t        pkt,
    input  logic        res_valid,
    input  logic        res_ready,
    input  res_t        res,
    output int          errors,
    output int          pending
);

    logic [21:0] window_len;
    logic [4:0]  alert_level;

    logic        trk_live    [TRACKERS];
    logic [31:0] trk_src     [TRACKERS];
    logic [31:0] trk_start   [TRACKERS];
    int          trk_cnt     [TRACKERS];
    logic        trk_alerted [TRACKERS];
    logic [15:0] trk_ports   [TRACKERS][PORT_SLOTS];

    res_t verdict_q[$];

    function automatic res_t score_packet(pkt_t p);
        res_t        r;
        int          hit;
        int          free_i;
        int          old_i;
        int          cnt;
        logic [31:0] old_t;
        r = '0;
        if (int'(p.ip_total_length) < int'(p.ip_header_bytes) + 20 ||
            (p.tcp_flags & FLAG_SYN) == 8'h00 || (p.tcp_flags & FLAG_ACK) != 8'h00)
        begin
            r.outcome = OUT_IGNORED;
            return r;
        end
        hit = -1;
        free_i = -1;
        old_i = 0;
        old_t = 32'hFFFF_FFFF;
        for (int i = 0; i < TRACKERS; i++)
        begin
            if (!trk_live[i])
            begin
                if (free_i < 0) free_i = i;
                continue;
            end
            // expire by wrapping age
            if (p.now_ms - trk_start[i] > {10'b0, window_len})
            begin
                trk_live[i] = 1'b0;
                if (free_i < 0) free_i = i;
                continue;
            end
            if (trk_src[i] == p.src_ip)
            begin
                hit = i;
                break;
            end
            if (trk_start[i] < old_t)
            begin
                old_t = trk_start[i];
                old_i = i;
            end
        end
        if (hit < 0)
        begin
            hit = (free_i >= 0) ? free_i : old_i;
            trk_live[hit]     = 1'b1;
            trk_src[hit]      = p.src_ip;
            trk_ports[hit][0] = p.dst_port;
            trk_cnt[hit]      = 1;
            trk_start[hit]    = p.now_ms;
            trk_alerted[hit]  = 1'b0;
            r.outcome         = OUT_NEW;
            r.tracker_index   = hit[3:0];
            r.distinct_ports  = 5'd1;
            return r;
        end
        cnt = (trk_cnt[hit] > PORT_SLOTS) ? PORT_SLOTS : trk_cnt[hit];
        r.tracker_index = hit[3:0];
        for (int k = 0; k < cnt; k++)
        begin
            if (trk_ports[hit][k] == p.dst_port)
            begin
                r.outcome = OUT_KNOWN;
                r.distinct_ports = cnt[4:0];
                return r;
            end
        end
        r.outcome = OUT_FULL;
        if (cnt < int'(alert_level) && cnt < PORT_SLOTS)
        begin
            trk_ports[hit][cnt] = p.dst_port;
            cnt++;
            r.outcome = OUT_ADDED;
        end
        trk_cnt[hit] = cnt;
        if (cnt >= int'(alert_level) && !trk_alerted[hit])
        begin
            trk_alerted[hit] = 1'b1;
            r.scan_alert = 1'b1;
        end
        r.distinct_ports = cnt[4:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            window_len  = WINDOW_RESET;
            alert_level = THRESH_RESET;
            for (int i = 0; i < TRACKERS; i++) trk_live[i] = 1'b0;
            verdict_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WINDOW)
                    window_len = pwdata[21:0];
                else
                    alert_level = pwdata[4:0];
            end
            if (res_valid && res_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result beat %p", res);
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (res.outcome !== want.outcome || res.scan_alert !== want.scan_alert ||
                        res.tracker_index !== want.tracker_index ||
                        res.distinct_ports !== want.distinct_ports)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("result mismatch: expected %p, got %p", want, res);
                    end
                end
            end
            if (pkt_valid && pkt_ready)
                verdict_q.push_back(score_packet(pkt));
            pending = verdict_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import spsd_pkg::*;

    localparam logic [2:0] ADDR_WINDOW = {REG_WINDOW, 2'b00};
    localparam logic [2:0] ADDR_THRESH = {REG_THRESH, 2'b00};
    localparam int         PHASES      = 7;
    localparam int         PER_PHASE   = 200;
    localparam int         CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        pkt_valid;
    logic        pkt_ready;
    pkt_t        pkt;
    logic        res_valid;
    logic        res_ready;
    res_t        res;
    int          errors;
    int          pending;

    int          sent;
    bit          quiet;
    int          cycles = 0;
    logic [31:0] clock_ms;
    logic [31:0] src_pool  [24];
    logic [15:0] port_pool [20];

    syn_port_scan_detector_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .pkt_valid(pkt_valid), .pkt_ready(pkt_ready), .pkt(pkt),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    scan_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .pkt_valid(pkt_valid), .pkt_ready(pkt_ready), .pkt(pkt),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stall bursts plus one long hold-off
    initial
    begin
        bit held;
        held = 1'b0;
        res_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent >= 300)
            begin
                held = 1'b1;
                res_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    task automatic send_beat(pkt_t p);
        pkt <= p;
        pkt_valid <= 1'b1;
        @(posedge clk);
        while (!pkt_ready) @(posedge clk);
        sent++;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            pkt_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        pkt_valid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        pkt_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic pkt_t make_pkt(logic [31:0] src, logic [15:0] port, logic [7:0] flags,
                                      logic [5:0] hdr, logic [15:0] total, logic [31:0] now);
        pkt_t p;
        p.src_ip = src;
        p.dst_port = port;
        p.tcp_flags = flags;
        p.ip_header_bytes = hdr;
        p.ip_total_length = total;
        p.now_ms = now;
        return p;
    endfunction

    // mostly well-formed SYNs from a small source set so trackers fill and evict
    function automatic pkt_t random_pkt(logic [21:0] win);
        pkt_t        p;
        int          roll;
        logic [7:0]  f;
        logic [5:0]  h;
        roll = $urandom_range(0, 99);
        h = 6'($urandom_range(0, 63));
        f = 8'($urandom);
        f = (f | FLAG_SYN) & ~FLAG_ACK;
        if (roll < 3)
            clock_ms = $urandom;
        else
            clock_ms = clock_ms + $urandom_range(0, win / 6 + 2);
        p = make_pkt(($urandom_range(0, 19) == 0) ? $urandom : src_pool[$urandom_range(0, 23)],
                     ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                 : port_pool[$urandom_range(0, 19)],
                     f, h, 16'($urandom_range(int'(h) + 20, 65535)), clock_ms);
        if (roll >= 88 && roll < 92)
            p.tcp_flags = 8'($urandom);
        else if (roll >= 92 && roll < 96)
            p.tcp_flags = f | FLAG_ACK;
        else if (roll >= 96)
            p.ip_total_length = 16'($urandom_range(0, int'(h) + 19));
        return p;
    endfunction

    initial
    begin
        logic [21:0] win_cfg [PHASES];
        logic [4:0]  thr_cfg [PHASES];
        win_cfg = '{22'd10000, 22'd1, 22'd0, 22'd3600000, 22'h3FFFFF, 22'd50, 22'd200};
        thr_cfg = '{5'd16, 5'd1, 5'd0, 5'd16, 5'd31, 5'd4, 5'd17};
        sent = 0;
        quiet = 1'b0;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        pkt_valid <= 1'b0;
        pkt <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: filtering edges, field extremes, known/added ports, expiry
        send_beat(make_pkt(32'h0A000001, 16'd80, 8'h00, 6'd20, 16'd40, 32'd0));
        send_beat(make_pkt(32'h0A000001, 16'd80, 8'h12, 6'd20, 16'd40, 32'd0));
        send_beat(make_pkt(32'h0A000001, 16'd80, 8'h02, 6'd63, 16'd82, 32'd0));
        send_beat(make_pkt(32'h0A000001, 16'd80, 8'hFF, 6'd63, 16'hFFFF, 32'd0));
        send_beat(make_pkt(32'h0A000001, 16'd80, 8'h02, 6'd63, 16'd83, 32'd1));
        send_beat(make_pkt(32'h0A000001, 16'd80, 8'hEF, 6'd0, 16'd20, 32'd2));
        send_beat(make_pkt(32'h0A000001, 16'd81, 8'h02, 6'd20, 16'd40, 32'd3));
        send_beat(make_pkt(32'hFFFFFFFF, 16'hFFFF, 8'hEF, 6'd60, 16'hFFFF, 32'd4));
        send_beat(make_pkt(32'h00000000, 16'h0000, 8'h02, 6'd0, 16'd20, 32'd5));
        send_beat(make_pkt(32'hFFFFFFFF, 16'h0000, 8'h02, 6'd20, 16'd40, 32'd10004));
        send_beat(make_pkt(32'hFFFFFFFF, 16'h0001, 8'h02, 6'd20, 16'd40, 32'd10005));
        send_beat(make_pkt(32'h0A000001, 16'd82, 8'h02, 6'd20, 16'd40, 32'hFFFFFFFF));
        send_beat(make_pkt(32'h0A000001, 16'd83, 8'h02, 6'd20, 16'd40, 32'd100));
        for (int i = 0; i < 17; i++)
            send_beat(make_pkt(32'hC0A80001, 16'(1000 + i), 8'h02, 6'd20, 16'd40, 32'd200));
        for (int i = 0; i < 18; i++)
            send_beat(make_pkt(32'h0B000000 + i, 16'd22, 8'h02, 6'd20, 16'd40, 32'd300 + i));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                reg_write(ADDR_WINDOW, {10'b0, win_cfg[ph]});
                reg_write(ADDR_THRESH, {27'b0, thr_cfg[ph]});
            end
            quiet = (ph == PHASES - 1);
            foreach (src_pool[i]) src_pool[i] = $urandom;
            foreach (port_pool[i]) port_pool[i] = 16'($urandom);
            clock_ms = $urandom;
            for (int n = 0; n < PER_PHASE; n++)
                send_beat(random_pkt(win_cfg[ph]));
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
